/* rtl/core/max_heap_priority_queue_unit_defines.svh */
// Assertion macros shared by the max-heap priority queue RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Property checked at every edge outside reset
`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mhpq_pkg.sv */
// Package for the max-heap priority queue: widths, codes, datapath ops, status struct.
// No dependencies.
package mhpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 7;

    // Item mode codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Operations the controller asks of the datapath
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PLACE,
        OP_UP_READ,
        OP_UP_CMP,
        OP_DN_TAKE,
        OP_DN_READ,
        OP_DN_CMP,
        OP_POST
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic at_root;
        logic up_stop;
        logic dn_leaf;
        logic dn_stop;
        logic out_full;
    } dp_stat_t;

endpackage

/* rtl/core/mhpq_in_if.sv */
// Request channel of the priority queue: valid/ready plus mode and key.
// Depends on mhpq_pkg.
interface mhpq_in_if;
    import mhpq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, mode, key, input ready);
    modport sink   (input valid, mode, key, output ready);
endinterface

/* rtl/core/mhpq_out_if.sv */
// Response channel of the priority queue: valid/ready plus result fields.
// Depends on mhpq_pkg.
interface mhpq_out_if;
    import mhpq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] removed_key;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_OUT_W-1:0]  count_after;

    modport source (output valid, removed_key, status, count_after, input ready);
    modport sink   (input valid, removed_key, status, count_after, output ready);
endinterface

/* rtl/core/mhpq_datapath.sv */
// Datapath: heap store memory, entry count, sift position, moving key, result register.
// Depends on mhpq_pkg and max_heap_priority_queue_unit_defines.svh.
`include "max_heap_priority_queue_unit_defines.svh"

module mhpq_datapath
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_op_t                     op,
    output dp_stat_t                   stat,
    input  logic                       in_mode,
    input  logic signed [KEY_W-1:0]    in_key,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [KEY_W-1:0]    out_key,
    output logic [STATUS_W-1:0]        out_status,
    output logic [COUNT_OUT_W-1:0]     out_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ROOT    = CNT_W'(1);

    // Store at positions 1..CAPACITY; position 0 unused
    logic signed [KEY_W-1:0] heap_mem [0:CAPACITY];

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] cur_key_reg, cur_key_next;
    logic signed [KEY_W-1:0] removed_reg, removed_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic signed [KEY_W-1:0] rd_a_reg, rd_b_reg;

    logic                    out_valid_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [COUNT_OUT_W-1:0]  out_count_reg;

    logic                    wr_en, rd_en;
    logic [CNT_W-1:0]        wr_addr, rd_addr_a, rd_addr_b;
    logic signed [KEY_W-1:0] wr_data;

    // Tree neighbors of the current position
    logic [CNT_W-1:0]        parent;
    logic [CNT_W:0]          left_pos, right_pos, count_wide;
    logic                    right_ok, take_l, take_r;
    logic signed [KEY_W-1:0] best_val, dest_val;
    logic [CNT_W-1:0]        dest_pos;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign parent     = pos_reg >> 1;
    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = {pos_reg, 1'b1};
    assign count_wide = {1'b0, count_reg};
    assign right_ok   = (right_pos <= count_wide);
    assign count_ext  = {{COUNT_OUT_W{1'b0}}, count_reg};

    // Sift-down choice: larger child, left first, no move on equal keys
    assign take_l   = (cur_key_reg < rd_a_reg);
    assign best_val = take_l ? rd_a_reg : cur_key_reg;
    assign take_r   = right_ok && (best_val < rd_b_reg);
    assign dest_val = take_r ? rd_b_reg : rd_a_reg;
    assign dest_pos = take_r ? right_pos[CNT_W-1:0] : left_pos[CNT_W-1:0];

    // Status toward the controller
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CAP_CNT);
    assign stat.at_root  = (pos_reg == ROOT);
    assign stat.up_stop  = !(rd_a_reg < cur_key_reg);
    assign stat.dn_leaf  = (left_pos > count_wide);
    assign stat.dn_stop  = !take_l && !take_r;
    assign stat.out_full = out_valid_reg && !out_ready;

    // Next-state and memory port control per operation
    always_comb
    begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        cur_key_next = cur_key_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = cur_key_reg;
        rd_en        = 1'b0;
        rd_addr_a    = ROOT;
        rd_addr_b    = '0;
        case (op)
            OP_LOAD:
            begin
                cur_key_next = in_key;
                removed_next = '0;
                status_next  = STATUS_OK;
                if (in_mode == MODE_INSERT)
                begin
                    if (stat.full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        pos_next   = count_reg + CNT_W'(1);
                    end
                end
                else if (stat.empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    // fetch root and last entry
                    rd_en     = 1'b1;
                    rd_addr_a = ROOT;
                    rd_addr_b = count_reg;
                end
            end
            OP_PLACE:
            begin
                wr_en = 1'b1;
            end
            OP_UP_READ:
            begin
                rd_en     = 1'b1;
                rd_addr_a = parent;
            end
            OP_UP_CMP:
            begin
                wr_en = 1'b1;
                if (!stat.up_stop)
                begin
                    wr_data  = rd_a_reg;
                    pos_next = parent;
                end
            end
            OP_DN_TAKE:
            begin
                removed_next = rd_a_reg;
                cur_key_next = rd_b_reg;
                count_next   = count_reg - CNT_W'(1);
                pos_next     = ROOT;
            end
            OP_DN_READ:
            begin
                rd_en     = 1'b1;
                rd_addr_a = left_pos[CNT_W-1:0];
                rd_addr_b = right_ok ? right_pos[CNT_W-1:0] : '0;
            end
            OP_DN_CMP:
            begin
                wr_en = 1'b1;
                if (!stat.dn_stop)
                begin
                    wr_data  = dest_val;
                    pos_next = dest_pos;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Heap store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= heap_mem[rd_addr_a];
            rd_b_reg <= heap_mem[rd_addr_b];
        end
    end

    // Working registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cur_key_reg <= cur_key_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        if (op == OP_POST)
        begin
            out_key_reg    <= removed_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    // Entry count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (op == OP_POST)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_key    = out_key_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

    `MHPQ_ASSERT(a_count_bound, count_reg <= CAP_CNT, "entry count above capacity")
    `MHPQ_ASSERT_NEXT(a_full_keeps_count, (op == OP_LOAD) && (in_mode == MODE_INSERT) && stat.full, $stable(count_reg), "rejected insert changed count")
    `MHPQ_ASSERT(a_post_slot_free, (op == OP_POST) |-> !(out_valid_reg && !out_ready), "result overwritten while stalled")
    `MHPQ_ASSERT(a_pos_in_range, (op == OP_UP_CMP || op == OP_DN_CMP || op == OP_PLACE) |-> (pos_reg != '0 && pos_reg <= CAP_CNT), "sift position out of range")

endmodule

/* rtl/core/mhpq_controller.sv */
// Controller: sequences load, sift-up, sift-down and result posting.
// Depends on mhpq_pkg.
module mhpq_controller
    import mhpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_mode,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_TAKE,
        S_DN_RD,
        S_DN_CMP,
        S_POST
    } state_t;

    state_t state_reg, state_next;

    // Op and next state
    always_comb
    begin
        op         = OP_IDLE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                    if (in_mode == MODE_INSERT)
                    begin
                        state_next = stat.full ? S_POST : S_UP_RD;
                    end
                    else
                    begin
                        state_next = stat.empty ? S_POST : S_DN_TAKE;
                    end
                end
            end
            S_UP_RD:
            begin
                op         = stat.at_root ? OP_PLACE : OP_UP_READ;
                state_next = stat.at_root ? S_POST : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                op         = OP_UP_CMP;
                state_next = stat.up_stop ? S_POST : S_UP_RD;
            end
            S_DN_TAKE:
            begin
                op         = OP_DN_TAKE;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                op         = stat.dn_leaf ? OP_PLACE : OP_DN_READ;
                state_next = stat.dn_leaf ? S_POST : S_DN_CMP;
            end
            S_DN_CMP:
            begin
                op         = OP_DN_CMP;
                state_next = stat.dn_stop ? S_POST : S_DN_RD;
            end
            S_POST:
            begin
                // wait for the result register to free up
                if (!stat.out_full)
                begin
                    op         = OP_POST;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

/* rtl/core/max_heap_priority_queue_unit.sv */
// Max-heap priority queue of signed 32-bit keys, CAPACITY entries.
// Channel request (valid/ready): mode 0 inserts key, mode 1 removes the largest key.
// Channel response (valid/ready): removed_key, status (ok, full, empty), count_after.
// Every request item yields exactly one response item, in order.
// One item is in work at a time; request.ready is high while the sequencer is idle.
// Rejected items (full insert, empty remove) go straight to the posting step, and the
// next item can be accepted in the cycle after the result is posted.
// Results sit in an output register: a new item is accepted while a result waits,
// and the block holds in its posting step only if the response side still stalls.
// Reset clears the entry count, the result valid flag and the control state; the store
// itself is not cleared, and only entries written since are ever used.
// Depends on mhpq_pkg, mhpq_in_if, mhpq_out_if, mhpq_controller, mhpq_datapath.
module max_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    mhpq_in_if.sink      request,
    mhpq_out_if.source   response
);

    dp_op_t   op;
    dp_stat_t stat;

    mhpq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_mode  (request.mode),
        .in_ready (request.ready),
        .stat     (stat),
        .op       (op)
    );

    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .stat       (stat),
        .in_mode    (request.mode),
        .in_key     (request.key),
        .out_ready  (response.ready),
        .out_valid  (response.valid),
        .out_key    (response.removed_key),
        .out_status (response.status),
        .out_count  (response.count_after)
    );

endmodule

/* sim/max_heap_priority_queue_unit_tb.sv */
// Self-checking testbench for max_heap_priority_queue_unit: a local heap predictor
// checks every response item. Depends on mhpq_pkg, mhpq_in_if, mhpq_out_if and the RTL.
`timescale 1ns / 1ps

module max_heap_priority_queue_unit_tb;
    import mhpq_pkg::*;

    localparam int QUEUE_DEPTH    = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct {
        logic signed [KEY_W-1:0] removed_key;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_OUT_W-1:0]  count_after;
    } heap_result_t;

    logic clk;
    logic rst_n;

    mhpq_in_if  request_ch ();
    mhpq_out_if response_ch ();

    max_heap_priority_queue_unit #(
        .CAPACITY (QUEUE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    // Predictor state: 1-based heap of keys and its fill level
    logic signed [KEY_W-1:0] heap_keys [1:QUEUE_DEPTH];
    int                      heap_count;

    heap_result_t pending_results [$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the response to one accepted item and update the predicted heap
    function automatic heap_result_t predict_heap_op(input logic op_mode,
                                                     input logic signed [KEY_W-1:0] op_key);
        heap_result_t            res;
        int                      pos;
        int                      parent;
        int                      lchild;
        int                      best;
        logic signed [KEY_W-1:0] tmp;
        res.removed_key = '0;
        res.status      = STATUS_OK;
        if (op_mode == MODE_INSERT)
        begin
            if (heap_count >= QUEUE_DEPTH)
                res.status = STATUS_FULL;
            else
            begin
                heap_count++;
                heap_keys[heap_count] = op_key;
                pos = heap_count;
                // sift up while the parent is strictly smaller
                while (pos > 1)
                begin
                    parent = pos / 2;
                    if (!(heap_keys[parent] < heap_keys[pos]))
                        break;
                    tmp               = heap_keys[parent];
                    heap_keys[parent] = heap_keys[pos];
                    heap_keys[pos]    = tmp;
                    pos               = parent;
                end
            end
        end
        else
        begin
            if (heap_count == 0)
                res.status = STATUS_EMPTY;
            else
            begin
                res.removed_key = heap_keys[1];
                heap_keys[1]    = heap_keys[heap_count];
                heap_count--;
                pos = 1;
                // sift down toward the larger child while it is strictly larger
                forever
                begin
                    lchild = pos * 2;
                    best   = pos;
                    if (lchild <= heap_count && heap_keys[best] < heap_keys[lchild])
                        best = lchild;
                    if (lchild + 1 <= heap_count && heap_keys[best] < heap_keys[lchild + 1])
                        best = lchild + 1;
                    if (best == pos)
                        break;
                    tmp             = heap_keys[best];
                    heap_keys[best] = heap_keys[pos];
                    heap_keys[pos]  = tmp;
                    pos             = best;
                end
            end
        end
        res.count_after = COUNT_OUT_W'(heap_count);
        return res;
    endfunction

    // Send one item; called and returns at a falling edge
    task automatic send_item(input logic op_mode, input logic signed [KEY_W-1:0] op_key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(negedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.mode  <= op_mode;
        request_ch.key   <= op_key;
        do
            @(posedge clk);
        while (!request_ch.ready);
        pending_results.push_back(predict_heap_op(op_mode, op_key));
        @(negedge clk);
    endtask

    // Hold the request side until every expected item has come back
    task automatic wait_drained();
        request_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Key mix: full range, a narrow band for duplicates, and the extremes
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(9))
            5, 6, 7: k = $signed($urandom_range(15)) - 8;
            8:       k = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Empty removes, extreme keys, equal keys, drain past empty
    task automatic test_directed_edges();
        send_item(MODE_REMOVE, 32'sd0);
        send_item(MODE_REMOVE, 32'sh1234_5678);
        send_item(MODE_INSERT, 32'sh7FFF_FFFF);
        send_item(MODE_INSERT, 32'sh8000_0000);
        send_item(MODE_INSERT, 32'sd0);
        send_item(MODE_INSERT, -32'sd1);
        send_item(MODE_INSERT, 32'sd1);
        send_item(MODE_INSERT, 32'sd5);
        send_item(MODE_INSERT, 32'sd5);
        send_item(MODE_INSERT, 32'sd5);
        send_item(MODE_INSERT, -32'sd5);
        send_item(MODE_INSERT, 32'sh7FFF_FFFF);
        repeat (11)
            send_item(MODE_REMOVE, 32'shFFFF_FFFF);
    endtask

    // Runs biased toward filling or draining so both full and empty are reached
    task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
        int left;
        int run_len;
        int insert_pct;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        left = n_items;
        while (left > 0)
        begin
            run_len = $urandom_range(100, 20);
            case ($urandom_range(2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 15;
            endcase
            for (int i = 0; i < run_len && left > 0; i++)
            begin
                if ($urandom_range(99) < insert_pct)
                    send_item(MODE_INSERT, pick_key());
                else
                    send_item(MODE_REMOVE, $urandom);
                left--;
            end
        end
    endtask

    // Response side stalls at random per cycle
    initial
    begin
        response_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            response_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each response item with the oldest expectation
    always @(posedge clk)
    begin
        heap_result_t exp_res;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result key=%0d status=%0d count=%0d", $time,
                         response_ch.removed_key, response_ch.status,
                         response_ch.count_after);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (response_ch.removed_key !== exp_res.removed_key)
                begin
                    $display("%0t: removed_key expected %0d actual %0d", $time,
                             exp_res.removed_key, response_ch.removed_key);
                    fail_count++;
                end
                if (response_ch.status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, response_ch.status);
                    fail_count++;
                end
                if (response_ch.count_after !== exp_res.count_after)
                begin
                    $display("%0t: count_after expected %0d actual %0d", $time,
                             exp_res.count_after, response_ch.count_after);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either channel
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((request_ch.valid && request_ch.ready) ||
                (response_ch.valid && response_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired, %0d items outstanding", $time,
                 pending_results.size());
        $display("** max_heap_priority_queue_unit: FAILED **");
        $finish;
    end

    // Test sequence
    initial
    begin
        fail_count       = 0;
        heap_count       = 0;
        send_idle_pct    = 14;
        recv_idle_pct    = 72;
        rst_n            = 1'b0;
        request_ch.valid = 1'b0;
        request_ch.mode  = MODE_INSERT;
        request_ch.key   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_random_traffic(470, 14, 72);
        wait_drained();
        test_random_traffic(470, 72, 14);
        test_random_traffic(470, 0, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("** max_heap_priority_queue_unit: PASSED **");
        else
            $display("** max_heap_priority_queue_unit: FAILED **");
        $finish;
    end

endmodule
